// ----- hw/rtl/tqe_pkg.sv -----
// ============================================================================
// tqe_pkg - timer queue expiry engine shared definitions
// Command and result codes, field widths, slot layout and state encodings.
// ============================================================================
`default_nettype none

package tqe_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int ID_W   = 16;
    localparam int TIME_W = 48;
    localparam int IV_W   = 40;

    // input command codes
    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_DEL  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ADD_ACK  = 2'd0;
    localparam logic [1:0] KIND_DEL_ACK  = 2'd1;
    localparam logic [1:0] KIND_EXPIRED  = 2'd2;
    localparam logic [1:0] KIND_TICK_END = 2'd3;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_DEL,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  expire;
        logic [IV_W-1:0]    interval;
        logic [TIME_W-1:0]  now;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  expire;
        logic [IV_W-1:0]    interval;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADDFIN,
        ST_EMIT,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/tqe_in_if.sv -----
// ============================================================================
// tqe_in_if - command channel
// Valid/ready channel that carries one command word.
// ============================================================================
`default_nettype none

interface tqe_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  cmd;
    logic [tqe_pkg::ID_W-1:0]    timer_id;
    logic [tqe_pkg::TIME_W-1:0]  expire_time;
    logic [tqe_pkg::IV_W-1:0]    repeat_interval;
    logic [tqe_pkg::TIME_W-1:0]  now_time;

    modport source (output valid, cmd, timer_id, expire_time, repeat_interval, now_time,
                    input ready);
    modport sink   (input valid, cmd, timer_id, expire_time, repeat_interval, now_time,
                    output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tqe_out_if.sv -----
// ============================================================================
// tqe_out_if - result channel
// Valid/ready channel that carries one result word.
// ============================================================================
`default_nettype none

interface tqe_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [tqe_pkg::ID_W-1:0]    out_id;
    logic                        ok;
    logic                        earliest_changed;
    logic [tqe_pkg::TIME_W-1:0]  next_deadline;
    logic                        deadline_valid;
    logic                        last;

    modport source (output valid, kind, out_id, ok, earliest_changed, next_deadline,
                    deadline_valid, last, input ready);
    modport sink   (input valid, kind, out_id, ok, earliest_changed, next_deadline,
                    deadline_valid, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tqe_ram.sv -----
// ============================================================================
// tqe_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module tqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tqe_front.sv -----
// ============================================================================
// tqe_front - command intake
// Accepts command words, drops unknown codes and queues the rest (2 deep).
// ============================================================================
`default_nettype none

module tqe_front (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tqe_in_if.sink      i_in,
    output logic        o_q_valid,
    input  wire logic   i_q_ready,
    output tqe_pkg::t_cmd o_q_cmd
);

    tqe_pkg::t_cmd r_ent [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    tqe_pkg::t_cmd n_cmd;
    logic          known;
    logic          push;
    logic          pop;

    always_comb begin
        n_cmd.id       = i_in.timer_id;
        n_cmd.expire   = i_in.expire_time;
        n_cmd.interval = i_in.repeat_interval;
        n_cmd.now      = i_in.now_time;
        n_cmd.op       = tqe_pkg::OP_ADD;
        known          = 1'b1;
        unique case (i_in.cmd)
            tqe_pkg::CMD_ADD:  n_cmd.op = tqe_pkg::OP_ADD;
            tqe_pkg::CMD_DEL:  n_cmd.op = tqe_pkg::OP_DEL;
            tqe_pkg::CMD_TICK: n_cmd.op = tqe_pkg::OP_TICK;
            default:           known    = 1'b0;
        endcase
    end

    assign i_in.ready = (r_cnt != 2'd2);
    // unknown words are taken and dropped
    assign push       = i_in.valid && i_in.ready && known;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign pop        = o_q_valid && i_q_ready;
    assign o_q_cmd    = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tqe_back.sv -----
// ============================================================================
// tqe_back - table engine
// Executes add, delete and tick by scanning the slot RAM one entry a cycle.
// ============================================================================
`default_nettype none

module tqe_back #(
    parameter int TABLE_DEPTH = tqe_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    output logic               o_q_ready,
    input  wire tqe_pkg::t_cmd i_q_cmd,
    tqe_out_if.source          o_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int TW = tqe_pkg::TIME_W;
    localparam int IW = tqe_pkg::ID_W;

    tqe_pkg::t_state r_state, n_state;
    tqe_pkg::t_cmd   r_cmd;

    logic [AW-1:0] r_addr;
    logic          r_issue;
    logic          r_pval;
    logic [AW-1:0] r_pidx;
    logic          r_rearm;

    logic          r_used [TABLE_DEPTH];
    logic          r_pick [TABLE_DEPTH];

    logic          r_any, n_any;
    logic [TW-1:0] r_min, n_min;
    logic          r_free_ok, n_free_ok;
    logic [AW-1:0] r_free, n_free;
    logic          r_found, n_found;
    logic          r_best_ok, n_best_ok;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic [TW-1:0] r_best_exp, n_best_exp;
    logic [IW-1:0] r_best_id, n_best_id;
    logic          r_res_ok;
    logic          r_res_ch;

    logic          r_ov;
    logic [1:0]    r_okind;
    logic [IW-1:0] r_oid;
    logic          r_ook;
    logic          r_och;
    logic [TW-1:0] r_ond;
    logic          r_odv;
    logic          r_olast;

    tqe_pkg::t_slot rd_slot;
    tqe_pkg::t_slot wr_slot;
    logic [tqe_pkg::SLOT_W-1:0] rd_data;

    logic          scan_done;
    logic          out_free;
    logic          slot_act;
    logic          u_cur;
    logic          pk_cur;
    logic          used_clr;
    logic          rewrite;
    logic          cand_ok;
    logic [TW-1:0] cand;
    logic [TW:0]   rearm_sum;
    logic [TW-1:0] rearm_exp;

    logic          c_start;
    logic          c_rearm_set;
    logic          c_we;
    logic [AW-1:0] c_waddr;
    logic          c_load_exp;
    logic          c_load_res;
    logic          add_ch;

    tqe_ram #(
        .WIDTH (tqe_pkg::SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (wr_slot),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    assign rd_slot   = rd_data;
    assign scan_done = r_pval && (r_pidx == AW'(TABLE_DEPTH - 1));
    assign out_free  = !r_ov || o_out.ready;
    assign slot_act  = (r_state == tqe_pkg::ST_SCAN) && r_pval;
    assign u_cur     = r_used[r_pidx];
    assign pk_cur    = r_pick[r_pidx];
    assign rearm_sum = {1'b0, r_cmd.now} + {{(TW + 1 - tqe_pkg::IV_W){1'b0}}, rd_slot.interval};
    assign rearm_exp = rearm_sum[TW] ? {TW{1'b1}} : rearm_sum[TW-1:0];
    assign add_ch    = r_free_ok && (!r_any || (r_cmd.expire < r_min));

    // per-slot evaluation of the entry coming out of the RAM
    always_comb begin
        n_any      = r_any;
        n_min      = r_min;
        n_free_ok  = r_free_ok;
        n_free     = r_free;
        n_found    = r_found;
        n_best_ok  = r_best_ok;
        n_best_idx = r_best_idx;
        n_best_exp = r_best_exp;
        n_best_id  = r_best_id;
        used_clr   = 1'b0;
        rewrite    = 1'b0;
        cand_ok    = 1'b0;
        cand       = rd_slot.expire;
        if (slot_act) begin
            case (r_cmd.op)
                tqe_pkg::OP_ADD: begin
                    if (!u_cur && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_pidx;
                    end
                    cand_ok = u_cur;
                end
                tqe_pkg::OP_DEL: begin
                    if (u_cur && !r_found && (rd_slot.id == r_cmd.id)) begin
                        n_found  = 1'b1;
                        used_clr = 1'b1;
                    end else begin
                        cand_ok = u_cur;
                    end
                end
                default: begin
                    if (!r_rearm) begin
                        // ascending scan: a tie on expiry and id keeps the lower slot
                        if (u_cur && !pk_cur && (rd_slot.expire <= r_cmd.now) &&
                            (!r_best_ok || (rd_slot.expire < r_best_exp) ||
                             ((rd_slot.expire == r_best_exp) && (rd_slot.id < r_best_id)))) begin
                            n_best_ok  = 1'b1;
                            n_best_idx = r_pidx;
                            n_best_exp = rd_slot.expire;
                            n_best_id  = rd_slot.id;
                        end
                    end else if (u_cur && pk_cur) begin
                        if (rd_slot.interval != '0) begin
                            rewrite = 1'b1;
                            cand_ok = 1'b1;
                            cand    = rearm_exp;
                        end else begin
                            used_clr = 1'b1;
                        end
                    end else begin
                        cand_ok = u_cur;
                    end
                end
            endcase
            if (cand_ok && (!r_any || (cand < r_min))) begin
                n_any = 1'b1;
                n_min = cand;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tqe_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = tqe_pkg::ST_SCAN;
                end
            end
            tqe_pkg::ST_SCAN: begin
                if (scan_done) begin
                    case (r_cmd.op)
                        tqe_pkg::OP_ADD: n_state = tqe_pkg::ST_ADDFIN;
                        tqe_pkg::OP_DEL: n_state = tqe_pkg::ST_RESULT;
                        default: begin
                            if (r_rearm) begin
                                n_state = tqe_pkg::ST_RESULT;
                            end else if (n_best_ok) begin
                                n_state = tqe_pkg::ST_EMIT;
                            end
                        end
                    endcase
                end
            end
            tqe_pkg::ST_ADDFIN: n_state = tqe_pkg::ST_RESULT;
            tqe_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = tqe_pkg::ST_SCAN;
                end
            end
            tqe_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = tqe_pkg::ST_IDLE;
                end
            end
            default: n_state = tqe_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_q_ready   = (r_state == tqe_pkg::ST_IDLE);
        c_rearm_set = (r_state == tqe_pkg::ST_SCAN) && scan_done &&
                      (r_cmd.op == tqe_pkg::OP_TICK) && !r_rearm && !n_best_ok;
        c_load_exp  = (r_state == tqe_pkg::ST_EMIT) && out_free;
        c_load_res  = (r_state == tqe_pkg::ST_RESULT) && out_free;
        c_start     = ((r_state == tqe_pkg::ST_IDLE) && i_q_valid) || c_load_exp ||
                      c_rearm_set;
        c_we        = 1'b0;
        c_waddr     = r_pidx;
        wr_slot     = rd_slot;
        if ((r_state == tqe_pkg::ST_ADDFIN) && r_free_ok) begin
            c_we             = 1'b1;
            c_waddr          = r_free;
            wr_slot.id       = r_cmd.id;
            wr_slot.expire   = r_cmd.expire;
            wr_slot.interval = r_cmd.interval;
        end else if (rewrite) begin
            c_we           = 1'b1;
            wr_slot.expire = rearm_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tqe_pkg::ST_IDLE;
            r_issue <= 1'b0;
            r_pval  <= 1'b0;
            r_ov    <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_used[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_pval  <= r_issue;
            if (c_start) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_addr == AW'(TABLE_DEPTH - 1))) begin
                r_issue <= 1'b0;
            end
            if (used_clr) begin
                r_used[r_pidx] <= 1'b0;
            end
            if ((r_state == tqe_pkg::ST_ADDFIN) && r_free_ok) begin
                r_used[r_free] <= 1'b1;
            end
            if (c_load_exp || c_load_res) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_addr;
        if (c_start) begin
            r_addr <= '0;
        end else if (r_issue && (r_addr != AW'(TABLE_DEPTH - 1))) begin
            r_addr <= r_addr + AW'(1);
        end

        r_free     <= n_free;
        r_best_idx <= n_best_idx;
        r_best_exp <= n_best_exp;
        r_best_id  <= n_best_id;

        // clear the scan results at the start of every scan
        if (c_start) begin
            r_any <= 1'b0;
            r_min <= '0;
        end else if ((r_state == tqe_pkg::ST_ADDFIN) && add_ch) begin
            r_any <= 1'b1;
            r_min <= r_cmd.expire;
        end else begin
            r_any <= n_any;
            r_min <= n_min;
        end
        if (c_start) begin
            r_free_ok <= 1'b0;
            r_found   <= 1'b0;
            r_best_ok <= 1'b0;
        end else begin
            r_free_ok <= n_free_ok;
            r_found   <= n_found;
            r_best_ok <= n_best_ok;
        end

        if ((r_state == tqe_pkg::ST_IDLE) && i_q_valid) begin
            r_cmd   <= i_q_cmd;
            r_rearm <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_pick[i] <= 1'b0;
            end
        end
        if (c_rearm_set) begin
            r_rearm <= 1'b1;
        end
        if (c_load_exp) begin
            r_pick[r_best_idx] <= 1'b1;
        end

        if (r_state == tqe_pkg::ST_ADDFIN) begin
            r_res_ok <= r_free_ok;
            r_res_ch <= add_ch;
        end

        if (c_load_exp) begin
            r_okind <= tqe_pkg::KIND_EXPIRED;
            r_oid   <= r_best_id;
            r_ook   <= 1'b0;
            r_och   <= 1'b0;
            r_ond   <= '0;
            r_odv   <= 1'b0;
            r_olast <= 1'b0;
        end else if (c_load_res) begin
            r_ond   <= r_any ? r_min : '0;
            r_odv   <= r_any;
            r_olast <= 1'b1;
            case (r_cmd.op)
                tqe_pkg::OP_ADD: begin
                    r_okind <= tqe_pkg::KIND_ADD_ACK;
                    r_oid   <= r_cmd.id;
                    r_ook   <= r_res_ok;
                    r_och   <= r_res_ch;
                end
                tqe_pkg::OP_DEL: begin
                    r_okind <= tqe_pkg::KIND_DEL_ACK;
                    r_oid   <= r_cmd.id;
                    r_ook   <= r_found;
                    r_och   <= 1'b0;
                end
                default: begin
                    r_okind <= tqe_pkg::KIND_TICK_END;
                    r_oid   <= '0;
                    r_ook   <= 1'b0;
                    r_och   <= 1'b0;
                end
            endcase
        end
    end

    assign o_out.valid            = r_ov;
    assign o_out.kind             = r_okind;
    assign o_out.out_id           = r_oid;
    assign o_out.ok               = r_ook;
    assign o_out.earliest_changed = r_och;
    assign o_out.next_deadline    = r_ond;
    assign o_out.deadline_valid   = r_odv;
    assign o_out.last             = r_olast;

endmodule

`default_nettype wire

// ----- hw/rtl/timer_queue_expiry_engine.sv -----
// ============================================================================
// timer_queue_expiry_engine - ordered timer table with expiry engine
// Add, delete and tick commands over a table of TABLE_DEPTH timer slots.
// ============================================================================
// Commands enter a two-word queue and run one at a time against a slot RAM
// that is read one entry per cycle. An add or a delete takes one full table
// scan. A tick takes one scan per expired timer, one more scan that finds
// nothing left due, and a final re-arm scan, plus any output stall. Each
// scan goes through the single RAM read port. Unknown command codes are
// accepted and dropped without a result. The output register lets the queue
// keep taking commands while a result waits.
`default_nettype none

module timer_queue_expiry_engine #(
    parameter int TABLE_DEPTH = tqe_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tqe_in_if.sink    i_in,
    tqe_out_if.source o_out
);

    logic          q_valid;
    logic          q_ready;
    tqe_pkg::t_cmd q_cmd;

    tqe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_cmd   (q_cmd)
    );

    tqe_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_cmd   (q_cmd),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// ----- dv/tqe_checker.sv -----
// ----------------------------------------------------------------------------
// tqe_checker - timer queue expiry engine scoreboard
// Watches the command and result channels, keeps its own timer table, predicts
// each command's results and compares them word by word as they leave.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tqe_checker #(
    parameter int DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tqe_in_if.sink    i_in,
    tqe_out_if.sink   i_out,
    output int        o_errors,
    output int        o_pending,
    output int        o_results,
    output int        o_expired
);
    localparam int IDW = tqe_pkg::ID_W;
    localparam int TW  = tqe_pkg::TIME_W;
    localparam int IVW = tqe_pkg::IV_W;

    typedef struct {
        logic [1:0]    kind;
        logic [IDW-1:0] id;
        logic          ok;
        logic          changed;
        logic [TW-1:0] deadline;
        logic          dvalid;
        logic          last;
    } t_res;

    localparam logic [TW-1:0] TIME_MAX = '1;

    logic           used  [DEPTH];
    logic [IDW-1:0] sid   [DEPTH];
    logic [TW-1:0]  sexp  [DEPTH];
    logic [IVW-1:0] siv   [DEPTH];
    t_res           expected_results[$];

    function automatic logic min_expiry(output logic [TW-1:0] m);
        logic any;
        any = 1'b0;
        m   = '0;
        for (int i = 0; i < DEPTH; i++)
            if (used[i] && (!any || sexp[i] < m)) begin
                m   = sexp[i];
                any = 1'b1;
            end
        return any;
    endfunction

    function automatic logic fires_first(int a, int b);
        if (sexp[a] != sexp[b]) return sexp[a] < sexp[b];
        if (sid[a] != sid[b]) return sid[a] < sid[b];
        return a < b;
    endfunction

    task automatic queue_result(logic [1:0] k, logic [IDW-1:0] id, logic ok, logic ch,
                                logic [TW-1:0] nd, logic dv, logic lst);
        t_res r;
        r.kind = k; r.id = id; r.ok = ok; r.changed = ch;
        r.deadline = nd; r.dvalid = dv; r.last = lst;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic predict_command(logic [1:0] cmd, logic [IDW-1:0] id,
                                   logic [TW-1:0] et, logic [IVW-1:0] iv,
                                   logic [TW-1:0] now);
        logic [TW-1:0] m;
        logic          any, ok, ch;
        int            free, best, cnt;
        logic          picked[DEPTH];
        int            order[DEPTH];
        logic [TW:0]   sum;
        ok = 1'b0; ch = 1'b0; free = -1; cnt = 0;
        case (cmd)
            tqe_pkg::CMD_ADD: begin
                for (int i = DEPTH - 1; i >= 0; i--) if (!used[i]) free = i;
                if (free >= 0) begin
                    any = min_expiry(m);
                    ch  = !any || et < m;
                    used[free] = 1'b1; sid[free] = id; sexp[free] = et; siv[free] = iv;
                    ok  = 1'b1;
                end
                any = min_expiry(m);
                queue_result(tqe_pkg::KIND_ADD_ACK, id, ok, ch, m, any, 1'b1);
            end
            tqe_pkg::CMD_DEL: begin
                for (int i = 0; i < DEPTH; i++)
                    if (!ok && used[i] && sid[i] == id) begin
                        used[i] = 1'b0;
                        ok = 1'b1;
                    end
                any = min_expiry(m);
                queue_result(tqe_pkg::KIND_DEL_ACK, id, ok, 1'b0, m, any, 1'b1);
            end
            tqe_pkg::CMD_TICK: begin
                for (int i = 0; i < DEPTH; i++) picked[i] = 1'b0;
                do begin
                    best = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (used[i] && !picked[i] && sexp[i] <= now &&
                            (best < 0 || fires_first(i, best)))
                            best = i;
                    if (best >= 0) begin
                        picked[best] = 1'b1;
                        order[cnt++] = best;
                    end
                end while (best >= 0);
                for (int k = 0; k < cnt; k++)
                    queue_result(tqe_pkg::KIND_EXPIRED, sid[order[k]], 1'b0, 1'b0, '0,
                                 1'b0, 1'b0);
                // re-arm repeating timers, saturating at the top of time
                for (int k = 0; k < cnt; k++) begin
                    if (siv[order[k]] != '0) begin
                        sum = {1'b0, now} + {{(TW + 1 - IVW){1'b0}}, siv[order[k]]};
                        sexp[order[k]] = sum[TW] ? TIME_MAX : sum[TW-1:0];
                    end else begin
                        used[order[k]] = 1'b0;
                    end
                end
                any = min_expiry(m);
                queue_result(tqe_pkg::KIND_TICK_END, '0, 1'b0, 1'b0, m, any, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [TW-1:0] exp_v,
                               logic [TW-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) used[i] = 1'b0;
            expected_results.delete();
            o_errors  = 0;
            o_results = 0;
            o_expired = 0;
            o_pending = 0;
        end else begin
            // drain the result first: a command accepted this edge cannot answer yet
            if (i_out.valid && i_out.ready) begin
                o_results++;
                if (i_out.kind == tqe_pkg::KIND_EXPIRED) o_expired++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result word kind %0d id %0h", i_out.kind,
                           i_out.out_id);
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("kind", TW'(e.kind), TW'(i_out.kind));
                    check_field("out_id", TW'(e.id), TW'(i_out.out_id));
                    check_field("ok", TW'(e.ok), TW'(i_out.ok));
                    check_field("earliest_changed", TW'(e.changed),
                                TW'(i_out.earliest_changed));
                    check_field("next_deadline", e.deadline, i_out.next_deadline);
                    check_field("deadline_valid", TW'(e.dvalid), TW'(i_out.deadline_valid));
                    check_field("last", TW'(e.last), TW'(i_out.last));
                end
            end
            if (i_in.valid && i_in.ready)
                predict_command(i_in.cmd, i_in.timer_id, i_in.expire_time,
                                i_in.repeat_interval, i_in.now_time);
            o_pending = expected_results.size();
        end
    end
endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb - timer queue expiry engine testbench
// Drives directed and random add/delete/tick and unknown-code words with random idle bursts on
// both channels; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    localparam int DEPTH = 16;
    localparam int IDW   = tqe_pkg::ID_W;
    localparam int TW    = tqe_pkg::TIME_W;
    localparam int IVW   = tqe_pkg::IV_W;

    // code outside the command set, taken and dropped by the block
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic calm = 0;
    int   errors, pending, results, expired;
    int   words_sent = 0;
    logic [TW-1:0] clock_now = '0;

    tqe_in_if  cmd_ch ();
    tqe_out_if res_ch ();

    timer_queue_expiry_engine #(.TABLE_DEPTH(DEPTH)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(cmd_ch.sink), .o_out(res_ch.source));

    tqe_checker #(.DEPTH(DEPTH)) i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(cmd_ch.sink), .i_out(res_ch.sink),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_expired(expired));

    always #5 i_clk = ~i_clk;

    initial begin
        cmd_ch.valid = 0; cmd_ch.cmd = tqe_pkg::CMD_ADD; cmd_ch.timer_id = '0;
        cmd_ch.expire_time = '0; cmd_ch.repeat_interval = '0; cmd_ch.now_time = '0;
    end

    // result side: bursts of low ready, none once the run calms down
    initial begin
        int gap;
        res_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 15);
                res_ch.ready = 0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                res_ch.ready = 1;
            end
        end
    end

    task automatic send(logic [1:0] c, logic [IDW-1:0] id, logic [TW-1:0] et,
                        logic [IVW-1:0] iv, logic [TW-1:0] now);
        if (!calm && $urandom_range(0, 4) == 0) begin
            cmd_ch.valid = 0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        cmd_ch.valid = 1; cmd_ch.cmd = c; cmd_ch.timer_id = id;
        cmd_ch.expire_time = et; cmd_ch.repeat_interval = iv; cmd_ch.now_time = now;
        // ready only moves at the rising edge, so its value here decides the next edge
        while (!cmd_ch.ready) @(negedge i_clk);
        @(negedge i_clk);
        cmd_ch.valid = 0;
        words_sent++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        int sel, k;
        logic [TW-1:0] t;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: empty table, extremes, duplicates, full table, saturation
        send(tqe_pkg::CMD_TICK, 16'hFFFF, '1, '1, '0);
        send(tqe_pkg::CMD_DEL, 16'h1234, '0, '0, '0);
        send(tqe_pkg::CMD_ADD, 16'hFFFF, '1, '1, '0);
        send(tqe_pkg::CMD_ADD, 16'h0000, 48'd100, 40'd0, '0);
        send(tqe_pkg::CMD_ADD, 16'h0007, 48'd100, 40'd50, '0);
        send(tqe_pkg::CMD_ADD, 16'h0007, 48'd100, 40'd0, '0);
        send(tqe_pkg::CMD_ADD, 16'h0005, 48'd100, 40'd0, '0);
        send(tqe_pkg::CMD_DEL, 16'h0007, '0, '0, '0);
        send(CMD_UNKNOWN, 16'hAAAA, '1, '1, '1);
        send(tqe_pkg::CMD_TICK, 16'h0000, '0, '0, 48'd100);
        send(tqe_pkg::CMD_TICK, 16'h0000, '0, '0, '1);
        for (k = 0; k < DEPTH + 1; k++)
            send(tqe_pkg::CMD_ADD, k[15:0], 48'(k * 3),
                 (k % 2 != 0) ? 40'hFF_FFFF_FFFF : 40'd0, '0);
        send(tqe_pkg::CMD_TICK, 16'h0000, '0, '0, 48'hFFFF_FFFF_FFF0);
        send(tqe_pkg::CMD_TICK, 16'h0000, '0, '0, '1);

        // random: time moves forward, ticks sweep what fell due
        for (int n = 0; n < 480; n++) begin
            if (n > 420) calm = 1;
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                t = clock_now + 48'($urandom_range(0, 400));
                if ($urandom_range(0, 19) == 0) t = 48'(rand64());
                send(tqe_pkg::CMD_ADD, 16'($urandom_range(0, 20)) |
                     ($urandom_range(0, 9) == 0 ? 16'($urandom) : 16'h0), t,
                     $urandom_range(0, 2) == 0 ? 40'd0 :
                     ($urandom_range(0, 9) == 0 ? 40'(rand64()) : 40'($urandom_range(1, 300))),
                     48'(rand64()));
            end else if (sel < 60) begin
                send(tqe_pkg::CMD_DEL, 16'($urandom_range(0, 22)), 48'(rand64()),
                     40'(rand64()), 48'(rand64()));
            end else if (sel < 97) begin
                clock_now = clock_now + 48'($urandom_range(0, 300));
                send(tqe_pkg::CMD_TICK, 16'($urandom), 48'(rand64()), 40'(rand64()),
                     clock_now);
            end else begin
                send(CMD_UNKNOWN, 16'($urandom), 48'(rand64()), 40'(rand64()),
                     48'(rand64()));
            end
        end

        k = 0;
        while (pending != 0 && k < 20000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (400) @(posedge i_clk);
        $display("Sent %0d command words; checked %0d result words, %0d expiries.",
                 words_sent, results, expired);
        if (errors == 0 && pending == 0) begin
            $display("** timer_queue_expiry_engine: PASSED **");
        end else begin
            $display("** timer_queue_expiry_engine: FAILED **");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("** timer_queue_expiry_engine: FAILED **");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/tqe_pkg.sv
hw/rtl/tqe_in_if.sv
hw/rtl/tqe_out_if.sv
hw/rtl/tqe_ram.sv
hw/rtl/tqe_front.sv
hw/rtl/tqe_back.sv
hw/rtl/timer_queue_expiry_engine.sv
dv/tqe_checker.sv
dv/tb.sv
